// ===== hw/rtl/svpm_pkg.sv =====
// Shared types, register codes and Q1.63 helper math for the stereo volume/pan mixer.
// No dependencies; every other RTL file references this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package svpm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int ACC_W      = 32;
	localparam int GAIN_W     = 16;
	localparam int LEVEL_W    = 15;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_VOLUME        = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAN           = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO_BUFFER = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MONO_SOURCE   = 4'd3;

	localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'hFFFF;

	localparam logic [63:0] Q_ONE      = 64'h8000_0000_0000_0000;
	localparam logic [63:0] TENTH_Q63  = 64'd922337203685477580;
	localparam logic [63:0] GAIN_SCALE = 64'd65535;
	localparam logic [10:0] DECADE_EXP = 11'd2000;

	// Level settings handed to the gain lookup
	typedef struct packed {
		logic signed [LEVEL_W-1:0] volume;
		logic signed [LEVEL_W-1:0] pan;
		logic                      stereo_buffer;
	} level_cfg_t;

	// Per-lane stage control
	typedef struct packed {
		logic adv_s1;
	} lane_ctl_t;

	// floor(a * b / 2^63), product below 2^127
	function automatic logic [63:0] mul_q63(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[126:63];
	endfunction

	// x^2000 by square and multiply, each product truncated
	function automatic logic [63:0] pow_decade(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [10:0] e;
		r = Q_ONE;
		b = x;
		e = DECADE_EXP;
		while (e != 11'd0) begin
			if (e[0]) begin
				r = mul_q63(r, b);
			end
			b = mul_q63(b, b);
			e = e >> 1;
		end
		return r;
	endfunction

	// Largest Q1.63 step whose 2000th power stays at or below one tenth
	function automatic logic [63:0] step_factor();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		lo = 64'd0;
		hi = Q_ONE;
		while ((hi - lo) > 64'd1) begin
			mid = lo + ((hi - lo) >> 1);
			if (pow_decade(mid) <= TENTH_Q63) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/svpm_gain.sv =====
// Gain lookup: attenuation ROM plus the two-stage update of the left/right gain registers.
// Depends on svpm_pkg (level_cfg_t, Q1.63 functions).
`timescale 1ns / 1ps
`default_nettype none

module svpm_gain #(
	parameter int ATTEN_TABLE_DEPTH = 16384
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          update,
	input  wire svpm_pkg::level_cfg_t          cfg,
	output logic      [svpm_pkg::GAIN_W-1:0]   left_gain,
	output logic      [svpm_pkg::GAIN_W-1:0]   right_gain,
	output logic                               busy
);

	localparam int ADDR_W = $clog2(ATTEN_TABLE_DEPTH);
	localparam logic [16:0] DEPTH_W17 = 17'(ATTEN_TABLE_DEPTH);

	logic [svpm_pkg::GAIN_W-1:0] atten_rom [ATTEN_TABLE_DEPTH];

	// Fill the ROM at start: entry a is 65535 times the 0.01 dB step factor to the power a
	initial begin
		logic [63:0] c;
		logic [63:0] p;
		logic [63:0] g;
		c = svpm_pkg::step_factor();
		p = svpm_pkg::Q_ONE;
		for (int a = 0; a < ATTEN_TABLE_DEPTH; a++) begin
			g = svpm_pkg::mul_q63(p, svpm_pkg::GAIN_SCALE);
			atten_rom[ADDR_W'(a)] = g[svpm_pkg::GAIN_W-1:0];
			p = svpm_pkg::mul_q63(p, c);
		end
	end

	logic signed [15:0] vol_ext;
	logic signed [15:0] pan_ext;
	logic signed [15:0] left_level;
	logic signed [15:0] right_level;
	logic        [15:0] left_att;
	logic        [15:0] right_att;
	logic               left_oor;
	logic               right_oor;
	logic [ADDR_W-1:0]  left_addr;
	logic [ADDR_W-1:0]  right_addr;

	logic                        upd_s1;
	logic                        upd_s2;
	logic [svpm_pkg::GAIN_W-1:0] left_rom_s1;
	logic [svpm_pkg::GAIN_W-1:0] right_rom_s1;
	logic                        left_oor_s1;
	logic                        right_oor_s1;
	logic [svpm_pkg::GAIN_W-1:0] left_gain_q;
	logic [svpm_pkg::GAIN_W-1:0] right_gain_q;

	always_comb begin
		vol_ext     = 16'(cfg.volume);
		pan_ext     = 16'(cfg.pan);
		left_level  = vol_ext;
		right_level = vol_ext;
		if (cfg.stereo_buffer) begin
			if (!pan_ext[15]) begin
				left_level = vol_ext - pan_ext;
			end else begin
				right_level = vol_ext + pan_ext;
			end
		end
		// clamp boost to 0 dB, then negate to an attenuation index
		left_att  = (!left_level[15]) ? 16'd0 : 16'(-left_level);
		right_att = (!right_level[15]) ? 16'd0 : 16'(-right_level);
		left_oor  = {1'b0, left_att} >= DEPTH_W17;
		right_oor = {1'b0, right_att} >= DEPTH_W17;
		left_addr  = left_oor ? '0 : left_att[ADDR_W-1:0];
		right_addr = right_oor ? '0 : right_att[ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		left_rom_s1  <= atten_rom[left_addr];
		right_rom_s1 <= atten_rom[right_addr];
		left_oor_s1  <= left_oor;
		right_oor_s1 <= right_oor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1       <= 1'b0;
			upd_s2       <= 1'b0;
			left_gain_q  <= svpm_pkg::GAIN_UNITY;
			right_gain_q <= svpm_pkg::GAIN_UNITY;
		end else begin
			upd_s1 <= update;
			upd_s2 <= upd_s1;
			if (upd_s2) begin
				left_gain_q  <= left_oor_s1 ? '0 : left_rom_s1;
				right_gain_q <= right_oor_s1 ? '0 : right_rom_s1;
			end
		end
	end

	assign left_gain  = left_gain_q;
	assign right_gain = right_gain_q;
	assign busy       = upd_s1 | upd_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/svpm_lane.sv =====
// One mixing lane: sample times gain registered, then arithmetic shift and 32-bit wrapping add.
// Depends on svpm_pkg (widths, lane_ctl_t).
`timescale 1ns / 1ps
`default_nettype none

module svpm_lane #(
	parameter int GAIN_SHIFT = 12
) (
	input  wire logic                                clk,
	input  wire svpm_pkg::lane_ctl_t                 ctl,
	input  wire logic signed [svpm_pkg::SAMPLE_W-1:0] sample,
	input  wire logic        [svpm_pkg::GAIN_W-1:0]   gain,
	input  wire logic        [svpm_pkg::ACC_W-1:0]    acc,
	output logic             [svpm_pkg::ACC_W-1:0]    sum
);

	localparam int PROD_W = svpm_pkg::SAMPLE_W + svpm_pkg::GAIN_W + 1;

	logic signed [PROD_W-1:0]         prod_s1;
	logic        [svpm_pkg::ACC_W-1:0] acc_s1;
	logic signed [PROD_W-1:0]         scaled;

	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			prod_s1 <= PROD_W'(sample) * PROD_W'($signed({1'b0, gain}));
			acc_s1  <= acc;
		end
	end

	// floor shift, then wrap into the accumulator
	assign scaled = prod_s1 >>> GAIN_SHIFT;
	assign sum    = acc_s1 + scaled[svpm_pkg::ACC_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/stereo_volume_pan_mixer_unit.sv =====
// Top level of the stereo volume/pan mixer: config registers, gain lookup, two lanes, output stage.
// Depends on svpm_pkg, svpm_gain and svpm_lane.
`timescale 1ns / 1ps
`default_nettype none

// Mixes one 16-bit stereo frame per request into a pair of 32-bit accumulators. Each side adds
// (sample * gain) >>> GAIN_SHIFT to its accumulator with 32-bit wraparound; with mono_source set
// the left sample and left gain feed both sides. Gains come from volume and pan (0.01 dB units)
// through an ATTEN_TABLE_DEPTH-entry attenuation ROM; attenuations past the table give gain 0.
// Throughput is one request per clock unless out_ready or a gain refresh holds it; each request
// passes the multiply stage in each lane, then the add into the output register. A config write starts a
// gain refresh through the ROM's registered read ports, and in_ready stays low during the write
// cycle and while the refresh is busy, until the new gains land. Config writes are only legal while
// no request is in flight. Register map: 0 volume, 1 pan, 2 stereo_buffer, 3 mono_source;
// other indexes are ignored.
module stereo_volume_pan_mixer_unit #(
	parameter int GAIN_SHIFT        = 12,
	parameter int ATTEN_TABLE_DEPTH = 16384
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// config write port
	input  wire logic                                  cfg_we,
	input  wire logic        [svpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic        [svpm_pkg::CFG_DATA_W-1:0] cfg_data,
	// input request channel
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [svpm_pkg::SAMPLE_W-1:0]   left_sample,
	input  wire logic signed [svpm_pkg::SAMPLE_W-1:0]   right_sample,
	input  wire logic signed [svpm_pkg::ACC_W-1:0]      left_acc_in,
	input  wire logic signed [svpm_pkg::ACC_W-1:0]      right_acc_in,
	input  wire logic                                  frame_last,
	// result channel
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed      [svpm_pkg::ACC_W-1:0]      left_acc_out,
	output logic signed      [svpm_pkg::ACC_W-1:0]      right_acc_out,
	output logic                                       frame_last_out
);

	// Configuration registers
	logic signed [svpm_pkg::LEVEL_W-1:0] volume_q;
	logic signed [svpm_pkg::LEVEL_W-1:0] pan_q;
	logic                                stereo_buffer_q;
	logic                                mono_source_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q        <= '0;
			pan_q           <= '0;
			stereo_buffer_q <= 1'b0;
			mono_source_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				svpm_pkg::REG_VOLUME:        volume_q        <= cfg_data;
				svpm_pkg::REG_PAN:           pan_q           <= cfg_data;
				svpm_pkg::REG_STEREO_BUFFER: stereo_buffer_q <= cfg_data[0];
				svpm_pkg::REG_MONO_SOURCE:   mono_source_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Gain lookup; refresh on every write (unknown indexes recompute the same gains)
	svpm_pkg::level_cfg_t        level_cfg;
	logic [svpm_pkg::GAIN_W-1:0] left_gain;
	logic [svpm_pkg::GAIN_W-1:0] right_gain;
	logic                        gain_busy;

	assign level_cfg.volume        = volume_q;
	assign level_cfg.pan           = pan_q;
	assign level_cfg.stereo_buffer = stereo_buffer_q;

	svpm_gain #(
		.ATTEN_TABLE_DEPTH(ATTEN_TABLE_DEPTH)
	) u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.update    (cfg_we),
		.cfg       (level_cfg),
		.left_gain (left_gain),
		.right_gain(right_gain),
		.busy      (gain_busy)
	);

	// Pipeline flow control: stage 1 holds the lane products, the output register holds results
	logic v_s1;
	logic out_valid_q;
	logic out_free;
	logic s1_free;
	logic accept;

	assign out_free = !out_valid_q || out_ready;
	assign s1_free  = !v_s1 || out_free;
	// hold off new requests while a gain refresh is in progress
	assign in_ready = s1_free && !gain_busy && !cfg_we;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= accept;
			end
			if (out_free) begin
				out_valid_q <= v_s1;
			end
		end
	end

	// Lane inputs: mono source steers the left sample and gain into the right lane
	svpm_pkg::lane_ctl_t                 lane_ctl;
	logic signed [svpm_pkg::SAMPLE_W-1:0] r_lane_sample;
	logic        [svpm_pkg::GAIN_W-1:0]   r_lane_gain;
	logic        [svpm_pkg::ACC_W-1:0]    left_sum;
	logic        [svpm_pkg::ACC_W-1:0]    right_sum;
	logic                                 frame_last_s1;

	assign lane_ctl.adv_s1 = accept;
	assign r_lane_sample   = mono_source_q ? left_sample : right_sample;
	assign r_lane_gain     = mono_source_q ? left_gain : right_gain;

	svpm_lane #(
		.GAIN_SHIFT(GAIN_SHIFT)
	) u_lane_left (
		.clk   (clk),
		.ctl   (lane_ctl),
		.sample(left_sample),
		.gain  (left_gain),
		.acc   (left_acc_in),
		.sum   (left_sum)
	);

	svpm_lane #(
		.GAIN_SHIFT(GAIN_SHIFT)
	) u_lane_right (
		.clk   (clk),
		.ctl   (lane_ctl),
		.sample(r_lane_sample),
		.gain  (r_lane_gain),
		.acc   (right_acc_in),
		.sum   (right_sum)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_last_s1 <= frame_last;
		end
	end

	// Merge: collect both lane sums and the frame marker into the output register
	logic [svpm_pkg::ACC_W-1:0] left_out_q;
	logic [svpm_pkg::ACC_W-1:0] right_out_q;
	logic                       frame_last_q;

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			left_out_q   <= left_sum;
			right_out_q  <= right_sum;
			frame_last_q <= frame_last_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign left_acc_out   = left_out_q;
	assign right_acc_out  = right_out_q;
	assign frame_last_out = frame_last_q;

endmodule

`default_nettype wire

// ===== bench/svpm_mix_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the stereo volume/pan mixer: tracks register writes, predicts each
// result from its own attenuation table and compares it. Depends on svpm_pkg for widths and codes.

module svpm_mix_checker #(
	parameter int GAIN_SHIFT  = 12,
	parameter int ATTEN_DEPTH = 16384
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic        [svpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic        [svpm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                                  in_valid,
	input  wire logic                                  in_ready,
	input  wire logic signed [svpm_pkg::SAMPLE_W-1:0]   left_sample,
	input  wire logic signed [svpm_pkg::SAMPLE_W-1:0]   right_sample,
	input  wire logic signed [svpm_pkg::ACC_W-1:0]      left_acc_in,
	input  wire logic signed [svpm_pkg::ACC_W-1:0]      right_acc_in,
	input  wire logic                                  frame_last,
	input  wire logic                                  out_valid,
	input  wire logic                                  out_ready,
	input  wire logic signed [svpm_pkg::ACC_W-1:0]      left_acc_out,
	input  wire logic signed [svpm_pkg::ACC_W-1:0]      right_acc_out,
	input  wire logic                                  frame_last_out,
	output int                                         mismatches,
	output int                                         pending
);

	localparam logic [63:0] Q63_UNITY   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] Q63_TENTH   = 64'd922337203685477580;
	localparam logic [10:0] DECADE_STEPS = 11'd2000;
	localparam int          LUT_AW      = $clog2(ATTEN_DEPTH);

	typedef struct packed {
		logic [svpm_pkg::ACC_W-1:0] left;
		logic [svpm_pkg::ACC_W-1:0] right;
		logic                       last;
	} mix_result_t;

	logic [svpm_pkg::GAIN_W-1:0]         atten_lut [ATTEN_DEPTH];
	logic signed [svpm_pkg::LEVEL_W-1:0] volume_q;
	logic signed [svpm_pkg::LEVEL_W-1:0] pan_q;
	logic                                stereo_q;
	logic                                mono_q;
	logic [svpm_pkg::GAIN_W-1:0]         gain_l;
	logic [svpm_pkg::GAIN_W-1:0]         gain_r;
	mix_result_t                         expected_mix [$];
	mix_result_t                         want;
	logic [svpm_pkg::ACC_W-1:0]          add_l;
	logic [svpm_pkg::ACC_W-1:0]          add_r;

	function automatic logic [63:0] q63_mul(input logic [63:0] x, input logic [63:0] y);
		logic [127:0] wide;
		wide = 128'(x) * 128'(y);
		return 64'(wide >> 63);
	endfunction

	// x^2000, LSB-first square and multiply with truncation at every product
	function automatic logic [63:0] q63_pow_decade(input logic [63:0] x);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = Q63_UNITY;
		sq = x;
		for (int k = 0; k < 11; k++) begin
			if (DECADE_STEPS[k]) begin
				acc = q63_mul(acc, sq);
			end
			sq = q63_mul(sq, sq);
		end
		return acc;
	endfunction

	function automatic logic [svpm_pkg::GAIN_W-1:0] level_to_gain(input int level);
		int atten;
		atten = (level > 0) ? 0 : -level;
		if (atten >= ATTEN_DEPTH) begin
			return '0;
		end
		return atten_lut[LUT_AW'(atten)];
	endfunction

	function automatic logic [svpm_pkg::ACC_W-1:0] scaled(
			input logic signed [svpm_pkg::SAMPLE_W-1:0] smp,
			input logic [svpm_pkg::GAIN_W-1:0] g);
		longint prod;
		longint shifted;
		prod = longint'(smp) * longint'(g);
		shifted = prod >>> GAIN_SHIFT;
		return shifted[svpm_pkg::ACC_W-1:0];
	endfunction

	// Build the attenuation table: find the per-step factor, then walk it down
	initial begin
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] level_q;
		logic [63:0] entry;
		lo = '0;
		hi = Q63_UNITY;
		while ((hi - lo) > 64'd1) begin
			mid = lo + ((hi - lo) >> 1);
			if (q63_pow_decade(mid) <= Q63_TENTH) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		level_q = Q63_UNITY;
		for (int a = 0; a < ATTEN_DEPTH; a++) begin
			entry = q63_mul(level_q, 64'd65535);
			atten_lut[LUT_AW'(a)] = entry[svpm_pkg::GAIN_W-1:0];
			level_q = q63_mul(level_q, lo);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int lvl_l;
		int lvl_r;
		if (!arst_n) begin
			volume_q = '0;
			pan_q = '0;
			stereo_q = 1'b0;
			mono_q = 1'b1;
			gain_l = svpm_pkg::GAIN_UNITY;
			gain_r = svpm_pkg::GAIN_UNITY;
			expected_mix.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready) begin
				add_l = scaled(left_sample, gain_l);
				add_r = mono_q ? add_l : scaled(right_sample, gain_r);
				want.left = left_acc_in + add_l;
				want.right = right_acc_in + add_r;
				want.last = frame_last;
				expected_mix.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (expected_mix.size() == 0) begin
					$display("%0t: result with nothing expected: left %h right %h last %b",
						$time, left_acc_out, right_acc_out, frame_last_out);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_mix.pop_front();
					if (left_acc_out !== want.left || right_acc_out !== want.right ||
							frame_last_out !== want.last) begin
						$display({"%0t: mismatch: expected left %h right %h last %b, ",
							"got left %h right %h last %b"},
							$time, want.left, want.right, want.last,
							left_acc_out, right_acc_out, frame_last_out);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					svpm_pkg::REG_VOLUME: begin
						volume_q = cfg_data;
					end
					svpm_pkg::REG_PAN: begin
						pan_q = cfg_data;
					end
					svpm_pkg::REG_STEREO_BUFFER: begin
						stereo_q = cfg_data[0];
					end
					svpm_pkg::REG_MONO_SOURCE: begin
						mono_q = cfg_data[0];
					end
					default: begin
					end
				endcase
				lvl_l = int'(volume_q);
				lvl_r = int'(volume_q);
				if (stereo_q) begin
					if (pan_q >= 0) begin
						lvl_l = int'(volume_q) - int'(pan_q);
					end else begin
						lvl_r = int'(volume_q) + int'(pan_q);
					end
				end
				gain_l = level_to_gain(lvl_l);
				gain_r = level_to_gain(lvl_r);
			end
			pending <= expected_mix.size();
		end
	end

endmodule

// ===== bench/stereo_volume_pan_mixer_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for stereo_volume_pan_mixer_unit: clock, reset, register writes and requests.
// Depends on svpm_pkg, the mixer RTL and svpm_mix_checker, which predicts and compares results.

module stereo_volume_pan_mixer_unit_tb;

	localparam int GAIN_SHIFT  = 12;
	localparam int ATTEN_DEPTH = 16384;

	logic                                  clk;
	logic                                  arst_n = 1'b0;
	logic                                  cfg_we = 1'b0;
	logic        [svpm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic        [svpm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                                  in_valid = 1'b0;
	logic                                  in_ready;
	logic signed [svpm_pkg::SAMPLE_W-1:0]   left_sample = '0;
	logic signed [svpm_pkg::SAMPLE_W-1:0]   right_sample = '0;
	logic signed [svpm_pkg::ACC_W-1:0]      left_acc_in = '0;
	logic signed [svpm_pkg::ACC_W-1:0]      right_acc_in = '0;
	logic                                  frame_last = 1'b0;
	logic                                  out_valid;
	logic                                  out_ready = 1'b0;
	logic signed [svpm_pkg::ACC_W-1:0]      left_acc_out;
	logic signed [svpm_pkg::ACC_W-1:0]      right_acc_out;
	logic                                  frame_last_out;

	int mismatches;
	int pending;
	// percent of cycles the request side sits idle / the result side stalls
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	stereo_volume_pan_mixer_unit #(
		.GAIN_SHIFT(GAIN_SHIFT),
		.ATTEN_TABLE_DEPTH(ATTEN_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.left_acc_in(left_acc_in),
		.right_acc_in(right_acc_in),
		.frame_last(frame_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_acc_out(left_acc_out),
		.right_acc_out(right_acc_out),
		.frame_last_out(frame_last_out)
	);

	svpm_mix_checker #(
		.GAIN_SHIFT(GAIN_SHIFT),
		.ATTEN_DEPTH(ATTEN_DEPTH)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.left_sample(left_sample),
		.right_sample(right_sample),
		.left_acc_in(left_acc_in),
		.right_acc_in(right_acc_in),
		.frame_last(frame_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_acc_out(left_acc_out),
		.right_acc_out(right_acc_out),
		.frame_last_out(frame_last_out),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the handshake locks up
	initial begin
		#10ms;
		$display("[stereo_volume_pan_mixer_unit] ERROR");
		$finish;
	end

	// Result side: stall at random by the current percentage, fresh draw every cycle
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// Hold until every accepted request has produced its result. The first edge lets the
	// checker's outstanding count catch up with an accept at the current edge.
	task automatic drain_requests();
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// One register write per clock; the caller lowers the write enable afterwards
	task automatic reg_write(input logic [svpm_pkg::CFG_IDX_W-1:0] idx,
			input logic [svpm_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Drop valid, drain, then rewrite all four registers plus junk_writes writes to unused
	// indexes, which the block must ignore
	task automatic program_mix(input int vol, input int pan, input bit stereo, input bit mono,
			input int junk_writes);
		logic [svpm_pkg::CFG_IDX_W-1:0] junk_idx;
		in_valid <= 1'b0;
		drain_requests();
		reg_write(svpm_pkg::REG_VOLUME, vol[svpm_pkg::CFG_DATA_W-1:0]);
		repeat (junk_writes) begin
			junk_idx = svpm_pkg::CFG_IDX_W'($urandom_range(4, 15));
			reg_write(junk_idx, svpm_pkg::CFG_DATA_W'($urandom));
		end
		reg_write(svpm_pkg::REG_PAN, pan[svpm_pkg::CFG_DATA_W-1:0]);
		reg_write(svpm_pkg::REG_STEREO_BUFFER, {{(svpm_pkg::CFG_DATA_W-1){1'b0}}, stereo});
		reg_write(svpm_pkg::REG_MONO_SOURCE, {{(svpm_pkg::CFG_DATA_W-1){1'b0}}, mono});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Present one request and hold it until accepted; idle first at the sender's rate
	task automatic send_frame(input logic [svpm_pkg::SAMPLE_W-1:0] ls,
			input logic [svpm_pkg::SAMPLE_W-1:0] rs,
			input logic [svpm_pkg::ACC_W-1:0] la, input logic [svpm_pkg::ACC_W-1:0] ra,
			input logic fl);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_sample <= ls;
		right_sample <= rs;
		left_acc_in <= la;
		right_acc_in <= ra;
		frame_last <= fl;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [svpm_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			default: return svpm_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [svpm_pkg::ACC_W-1:0] pick_acc();
		case ($urandom_range(0, 11))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Level in 0.01 dB: mostly the legal range, with the 15-bit extremes, positive
	// (clamped) values and attenuations right at the end of the table mixed in
	function automatic int pick_level(input bit is_pan);
		case ($urandom_range(0, 7))
			0: return 0;
			1: return -10000;
			2: return is_pan ? 10000 : -5000;
			3: return -16384;
			4: return 16383;
			5: return is_pan ? int'($urandom_range(0, 20000)) - 10000
				: -int'($urandom_range(0, 10000));
			6: return int'($urandom_range(0, 32767)) - 16384;
			default: return -int'($urandom_range(16000, 16383));
		endcase
	endfunction

	initial begin
		int junk;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: mono source, unity gain on both sides
		send_frame(16'h7FFF, 16'h1234, 32'h0, 32'h0, 1'b0);
		send_frame(16'h8000, 16'h7FFF, 32'h0, 32'h0, 1'b1);
		// a tiny negative product must round toward minus infinity
		send_frame(16'hFFFF, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		// wrap both accumulators past the signed limits
		send_frame(16'h7FFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFF0, 1'b1);
		send_frame(16'h8000, 16'h0001, 32'h8000_0000, 32'h8000_0005, 1'b0);

		// Stereo buffer, full positive pan: left attenuated by 100 dB
		program_mix(0, 10000, 1'b1, 1'b0, 0);
		send_frame(16'h7FFF, 16'h8000, 32'h0, 32'h0, 1'b0);
		send_frame(16'h8000, 16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

		// Right side pushed past the end of the table: its gain drops to zero
		program_mix(-10000, -10000, 1'b1, 1'b0, 0);
		send_frame(16'h7FFF, 16'h7FFF, 32'h1234_5678, 32'h1234_5678, 1'b0);
		send_frame(16'h8000, 16'h8000, 32'hFFFF_FFFF, 32'h0, 1'b1);

		// Stereo source into a mono buffer: pan ignored, positive volume clamps to 0 dB
		program_mix(16383, -16384, 1'b0, 1'b0, 0);
		send_frame(16'h7FFF, 16'h8000, 32'h0, 32'h0, 1'b0);
		send_frame(16'h4000, 16'hC000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);

		// Last table entry on the right, one step beyond it on the left
		program_mix(-16383, 1, 1'b1, 1'b0, 0);
		send_frame(16'h7FFF, 16'h7FFF, 32'h0, 32'h0, 1'b0);
		send_frame(16'h8000, 16'h8000, 32'h0, 32'h0, 1'b1);

		// Writes to unused indexes, most negative volume, mono source with pan applied
		program_mix(-16384, 16383, 1'b1, 1'b1, 4);
		send_frame(16'h7FFF, 16'h5555, 32'h0, 32'h0, 1'b0);
		send_frame(16'h8000, 16'hAAAA, 32'hFFFF_FFFF, 32'h1, 1'b1);

		// Moderate mono-source setting with pan on the quieter side
		program_mix(-600, -300, 1'b1, 1'b1, 0);
		send_frame(16'h7FFF, 16'h0, 32'h0, 32'h0, 1'b0);
		send_frame(16'h8001, 16'h0, 32'h0, 32'h0, 1'b1);

		// Random phases: new settings each time, cycling through the idle/stall patterns
		for (int phase = 0; phase < 12; phase++) begin
			junk = ($urandom_range(0, 3) == 0) ? 1 : 0;
			program_mix(pick_level(1'b0), pick_level(1'b1), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), junk);
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 86;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 86;
				end
				default: begin
					sender_idle_pct = 36;
					receiver_stall_pct = 36;
				end
			endcase
			repeat (100) begin
				send_frame(pick_sample(), pick_sample(), pick_acc(), pick_acc(),
					1'($urandom_range(0, 1)));
			end
		end

		// Release the result side and let the pipeline empty
		in_valid <= 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		drain_requests();
		repeat (4) @(posedge clk);

		if (mismatches == 0 && pending == 0) begin
			$display("[stereo_volume_pan_mixer_unit] OK");
		end else begin
			$display("[stereo_volume_pan_mixer_unit] ERROR");
		end
		$finish;
	end

endmodule
